FILE: hw/rtl/rta_pkg.sv
// Package for the RGB to ANSI 16-color quantizer.
// Holds palette levels, word types passed along the cell chain and code helpers.
// No dependencies.
package rta_pkg;

    localparam int CHANNELS   = 3;
    localparam int LEVELS     = 4;
    localparam int ENTRIES    = 16;
    localparam int SQ_W       = 16;
    localparam int DIST_W     = 18;
    localparam int IDX_W      = 4;

    // channel level codes
    localparam logic [1:0] LV_ZERO = 2'd0;
    localparam logic [1:0] LV_LOW  = 2'd1;
    localparam logic [1:0] LV_MED  = 2'd2;
    localparam logic [1:0] LV_MAX  = 2'd3;

    localparam logic [7:0] LEVEL_LOW = 8'd128;
    localparam logic [7:0] LEVEL_MED = 8'd192;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    localparam logic [2:0] HUE_BLACK = 3'd0;
    localparam logic [2:0] HUE_WHITE = 3'd7;

    localparam logic [6:0] CODE_BASE   = 7'd30;
    localparam logic [6:0] CODE_BACK   = 7'd10;
    localparam logic [6:0] CODE_BRIGHT = 7'd60;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef logic [CHANNELS-1:0][LEVELS-1:0][SQ_W-1:0] sq_t;

    typedef struct packed {
        sq_t               sq;
        logic              fore;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } chain_t;

    function automatic logic [7:0] level_value(input logic [1:0] lv);
        logic [7:0] v;
        case (lv)
            LV_ZERO: v = 8'd0;
            LV_LOW:  v = LEVEL_LOW;
            LV_MED:  v = LEVEL_MED;
            LV_MAX:  v = LEVEL_MAX;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // level code of one channel of one palette entry; idx[3] is intense
    function automatic logic [1:0] level_sel(input logic [IDX_W-1:0] idx,
                                             input logic [1:0] ch);
        logic [2:0] hue;
        logic       intense;
        logic [1:0] lv;
        hue     = idx[2:0];
        intense = idx[3];
        if (hue == HUE_BLACK) begin
            lv = intense ? LV_LOW : LV_ZERO;
        end else if (hue == HUE_WHITE) begin
            lv = intense ? LV_MAX : LV_MED;
        end else if (hue[ch]) begin
            lv = intense ? LV_MAX : LV_LOW;
        end else begin
            lv = LV_ZERO;
        end
        return lv;
    endfunction

    function automatic logic [6:0] sgr_code(input logic [IDX_W-1:0] idx,
                                            input logic fore);
        logic [6:0] c;
        c = {4'd0, idx[2:0]} + CODE_BASE;
        if (!fore) begin
            c = c + CODE_BACK;
        end
        if (idx[3]) begin
            c = c + CODE_BRIGHT;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/rta_if.sv
// Valid/ready channel interfaces for the quantizer: pixel in, SGR code out.
// No dependencies.
interface rta_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       fore_select;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output fore_select, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input fore_select, output ready);
endinterface

interface rta_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] ansi_code;
    logic [2:0] hue_index;
    logic       bright_flag;

    modport source (output valid, output ansi_code, output hue_index,
                    output bright_flag, input ready);
    modport sink   (input valid, input ansi_code, input hue_index,
                    input bright_flag, output ready);
endinterface

FILE: hw/rtl/rta_sqr.sv
// Front stage: squared distance of each channel to each of the four levels.
// Depends on rta_pkg.
module rta_sqr (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      red_in,
    input  logic [7:0]      green_in,
    input  logic [7:0]      blue_in,
    input  logic            fore_select,
    output logic            out_valid,
    input  logic            out_ready,
    output rta_pkg::chain_t out_word
);
    import rta_pkg::*;

    logic        valid_reg;
    chain_t      word_reg;
    chain_t      word_next;
    logic [7:0]  chan [CHANNELS];
    logic [7:0]  lvl;
    logic [7:0]  diff;

    assign chan[0] = red_in;
    assign chan[1] = green_in;
    assign chan[2] = blue_in;

    always_comb
    begin
        word_next           = '0;
        lvl                 = '0;
        diff                = '0;
        word_next.fore      = fore_select;
        word_next.best_dist = DIST_NONE;
        word_next.best_idx  = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                lvl  = level_value(2'(l));
                diff = (chan[c] > lvl) ? (chan[c] - lvl) : (lvl - chan[c]);
                word_next.sq[c][l] = {8'd0, diff} * {8'd0, diff};
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hw/rtl/rta_cell.sv
// Compare cell: distance to one palette entry, keeps the nearer of it and the
// best so far, passes the word on. Depends on rta_pkg.
module rta_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rta_pkg::IDX_W-1:0] entry_idx,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rta_pkg::chain_t           in_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rta_pkg::chain_t           out_word
);
    import rta_pkg::*;

    logic              valid_reg;
    chain_t            word_reg;
    chain_t            word_next;
    logic [DIST_W-1:0] entry_dist;

    always_comb
    begin
        entry_dist = {2'd0, in_word.sq[0][level_sel(entry_idx, 2'd0)]}
                   + {2'd0, in_word.sq[1][level_sel(entry_idx, 2'd1)]}
                   + {2'd0, in_word.sq[2][level_sel(entry_idx, 2'd2)]};
        word_next = in_word;
        // strict less: on a tie the earlier entry stays
        if (entry_dist < in_word.best_dist)
        begin
            word_next.best_dist = entry_dist;
            word_next.best_idx  = entry_idx;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hw/rtl/rgb_to_ansi16_quantizer.sv
// RGB to ANSI 16-color quantizer top level.
// Depends on rta_pkg, rta_if, rta_sqr and rta_cell.
//
// Takes one pixel word per clock and returns one SGR code word per pixel, in
// order. A pixel passes a squaring stage, a chain of 16 compare cells (one per
// palette entry, normal hues first) and an output register. Sustained rate is
// one word per cycle; each stage holds one word, and a stall on the result
// side backs up stage by stage, so the input keeps taking words until the
// chain is full.
module rgb_to_ansi16_quantizer (
    input  logic      clk,
    input  logic      rst_n,
    rta_pix_if.sink   pixel,
    rta_res_if.source result
);
    import rta_pkg::*;

    localparam int LINKS = ENTRIES + 1;

    chain_t link_word  [LINKS];
    logic   link_valid [LINKS];
    logic   link_ready [LINKS];

    logic       res_valid_reg;
    logic [6:0] code_reg;
    logic [2:0] hue_reg;
    logic       bright_reg;
    logic       res_ready;

    rta_sqr u_sqr (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pixel.valid),
        .in_ready    (pixel.ready),
        .red_in      (pixel.red_in),
        .green_in    (pixel.green_in),
        .blue_in     (pixel.blue_in),
        .fore_select (pixel.fore_select),
        .out_valid   (link_valid[0]),
        .out_ready   (link_ready[0]),
        .out_word    (link_word[0])
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rta_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .entry_idx (IDX_W'(i)),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_word   (link_word[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_word  (link_word[i+1])
        );
    end

    assign res_ready               = !res_valid_reg || result.ready;
    assign link_ready[LINKS-1]     = res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            res_valid_reg <= link_valid[LINKS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_valid[LINKS-1] && res_ready)
        begin
            code_reg   <= sgr_code(link_word[LINKS-1].best_idx, link_word[LINKS-1].fore);
            hue_reg    <= link_word[LINKS-1].best_idx[2:0];
            bright_reg <= link_word[LINKS-1].best_idx[3];
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.ansi_code   = code_reg;
    assign result.hue_index   = hue_reg;
    assign result.bright_flag = bright_reg;

endmodule

FILE: hw/rtl/rta_checker.sv
// Port-level checks for the quantizer, bound to the top level.
// Depends on rgb_to_ansi16_quantizer and rta_pkg.
module rta_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] ansi_code,
    input logic [2:0] hue_index,
    input logic       bright_flag
);
    import rta_pkg::*;

    logic [6:0] code_off;
    assign code_off = ansi_code - {4'd0, hue_index};

    // an empty or draining output lets the whole chain move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled while result side can move");

    // code, hue and intensity agree
    a_code_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!bright_flag && (code_off == CODE_BASE
                                         || code_off == CODE_BASE + CODE_BACK))
                    || (bright_flag && (code_off == CODE_BASE + CODE_BRIGHT
                                        || code_off == CODE_BASE + CODE_BACK + CODE_BRIGHT))))
        else $error("ansi_code does not match hue_index and bright_flag");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(ansi_code)
                                       && $stable(hue_index) && $stable(bright_flag)))
        else $error("stalled result word changed");

endmodule

bind rgb_to_ansi16_quantizer rta_checker u_rta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixel.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .ansi_code   (result.ansi_code),
    .hue_index   (result.hue_index),
    .bright_flag (result.bright_flag)
);
